@@ sv/fprc_pkg.sv @@
`timescale 1ns / 1ps

package fprc_pkg;

    localparam int DEF_MAX_TAPS = 16;

    localparam int OPCODE_W     = 2;
    localparam int SAMPLE_W     = 16;
    localparam int COEF_INDEX_W = 4;
    localparam int COEF_W       = 32;
    localparam int TAP_COUNT_W  = 5;
    localparam int PROD_W       = SAMPLE_W + COEF_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ENCODE     = 2'd0,
        OP_DECODE     = 2'd1,
        OP_COEF_WRITE = 2'd2,
        OP_CLEAR      = 2'd3
    } fprc_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_DONE
    } fprc_state_t;

endpackage

@@ sv/fir_prediction_residual_codec_unit.sv @@
`timescale 1ns / 1ps

// Channel   | Ports                                             | Direction
// ----------+---------------------------------------------------+----------
// input     | s_valid s_ready s_opcode s_sample_in s_coef_index | in
//           | s_coef_value                                      |
// result    | m_valid m_ready m_value_out m_saturated           | out
// config    | cfg_valid cfg_ready cfg_data (tap count)          | in
//
// An encode or decode item makes one read per tap in use on the memories' single
// port, drains the read and product stages, then passes rounding and write-back
// into the result register; with no taps in use it goes straight to rounding.
// The next transfer is taken in the cycle after write-back. Coefficient writes
// and history clears give no result. Reset is synchronous and empties the
// memories through their valid bits at once; a stalled result holds the
// write-back cycle until the result register is free.

module fir_prediction_residual_codec_unit #(
    parameter int MAX_TAPS = fprc_pkg::DEF_MAX_TAPS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [fprc_pkg::OPCODE_W-1:0]          s_opcode,
    input  logic signed [fprc_pkg::SAMPLE_W-1:0]   s_sample_in,
    input  logic [fprc_pkg::COEF_INDEX_W-1:0]      s_coef_index,
    input  logic signed [fprc_pkg::COEF_W-1:0]     s_coef_value,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [fprc_pkg::SAMPLE_W-1:0]   m_value_out,
    output logic                                   m_saturated,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [fprc_pkg::TAP_COUNT_W-1:0]       cfg_data
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam int SW = fprc_pkg::SAMPLE_W;
    localparam int KW = fprc_pkg::COEF_W;
    localparam int PW = fprc_pkg::PROD_W;

    fprc_pkg::fprc_state_t state_reg, state_next;

    logic [fprc_pkg::TAP_COUNT_W-1:0] tap_count_reg;

    // Storage: history ring and coefficient table, each with per-entry valid bits.
    logic [SW-1:0]       hist_mem [MAX_TAPS];
    logic [KW-1:0]       coef_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0] hist_vld_reg;
    logic [MAX_TAPS-1:0] coef_vld_reg;
    logic [AW-1:0]       newest_reg;

    logic [SW-1:0] hist_q_reg;
    logic [KW-1:0] coef_q_reg;
    logic          hist_qv_reg;
    logic          coef_qv_reg;

    logic [CW-1:0] count_reg;
    logic [AW-1:0] hist_addr_reg;
    logic [AW-1:0] coef_addr_reg;
    logic          rd_vld_reg;
    logic          prod_vld_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [KW-1:0] acc_reg;
    logic          sat_reg;
    logic [SW-1:0] pred_reg;
    logic          decode_reg;
    logic [SW-1:0] sample_reg;

    logic          m_valid_reg;
    logic [SW-1:0] m_value_out_reg;
    logic          m_saturated_reg;

    logic          start;
    logic          issue;
    logic          finish;
    logic [CW-1:0] tap_n;
    logic [CW-1:0] tap_last;
    logic          op_predict;
    logic          coef_we;
    logic          hist_clear;
    logic [AW-1:0] newest_inc;
    logic [SW-1:0] meas;
    logic [SW-1:0] value_next;

    logic signed [SW-1:0] mul_a;
    logic signed [KW-1:0] mul_b;
    logic signed [PW-1:0] prod_next;
    logic                 prod_ovf;
    logic signed [KW-1:0] prod_clamp;
    logic signed [KW:0]   sum_wide;
    logic                 sum_ovf;
    logic signed [KW-1:0] acc_next;

    logic              acc_neg;
    logic [KW:0]       acc_mag;
    logic [KW:0]       acc_rnd;
    logic [KW-16:0]    quot;
    logic [SW-1:0]     pred_next;

    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_value_out = m_value_out_reg;
    assign m_saturated = m_saturated_reg;

    // Taps in use, with counts above the table depth acting as the full depth.
    always_comb begin
        if (32'(tap_count_reg) > 32'(MAX_TAPS)) begin
            tap_n = CW'(MAX_TAPS);
        end else begin
            tap_n = CW'(tap_count_reg);
        end
        tap_last = tap_n - CW'(1);
    end

    assign op_predict = (s_opcode == fprc_pkg::OP_ENCODE) ||
                        (s_opcode == fprc_pkg::OP_DECODE);
    assign coef_we    = s_valid && s_ready && (s_opcode == fprc_pkg::OP_COEF_WRITE) &&
                        (32'(s_coef_index) < 32'(MAX_TAPS));
    assign hist_clear = s_valid && s_ready && (s_opcode == fprc_pkg::OP_CLEAR);
    assign newest_inc = (newest_reg == AW'(MAX_TAPS - 1)) ? '0 : newest_reg + AW'(1);

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        start      = 1'b0;
        issue      = 1'b0;
        finish     = 1'b0;
        unique case (state_reg)
            fprc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && op_predict) begin
                    start      = 1'b1;
                    state_next = (tap_n == '0) ? fprc_pkg::ST_ROUND : fprc_pkg::ST_MAC;
                end
            end
            fprc_pkg::ST_MAC: begin
                issue = 1'b1;
                if (count_reg == CW'(1)) begin
                    state_next = fprc_pkg::ST_DRAIN;
                end
            end
            fprc_pkg::ST_DRAIN: begin
                if (!rd_vld_reg && !prod_vld_reg) begin
                    state_next = fprc_pkg::ST_ROUND;
                end
            end
            fprc_pkg::ST_ROUND: begin
                state_next = fprc_pkg::ST_DONE;
            end
            fprc_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    finish     = 1'b1;
                    state_next = fprc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fprc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fprc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            tap_count_reg <= cfg_data;
        end
    end

    // Memory arrays: one write and one registered read per cycle each.
    always_ff @(posedge aclk) begin
        if (finish) begin
            hist_mem[newest_inc] <= meas;
        end
        if (issue) begin
            hist_q_reg <= hist_mem[hist_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[AW'(s_coef_index)] <= s_coef_value;
        end
        if (issue) begin
            coef_q_reg <= coef_mem[coef_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            hist_qv_reg <= hist_vld_reg[hist_addr_reg];
            coef_qv_reg <= coef_vld_reg[coef_addr_reg];
        end
    end

    // An entry never written since reset (or, for the history, since a clear) reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_vld_reg <= '0;
            coef_vld_reg <= '0;
            newest_reg   <= '0;
        end else begin
            if (hist_clear) begin
                hist_vld_reg <= '0;
                newest_reg   <= '0;
            end else if (finish) begin
                hist_vld_reg[newest_inc] <= 1'b1;
                newest_reg               <= newest_inc;
            end
            if (coef_we) begin
                coef_vld_reg[AW'(s_coef_index)] <= 1'b1;
            end
        end
    end

    // The history walks back from the newest sample while the coefficient
    // index walks down from the last tap in use.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            count_reg     <= tap_n;
            hist_addr_reg <= newest_reg;
            coef_addr_reg <= tap_last[AW-1:0];
            decode_reg    <= (s_opcode == fprc_pkg::OP_DECODE);
            sample_reg    <= s_sample_in;
        end else if (issue) begin
            count_reg     <= count_reg - CW'(1);
            hist_addr_reg <= (hist_addr_reg == '0) ? AW'(MAX_TAPS - 1)
                                                   : hist_addr_reg - AW'(1);
            coef_addr_reg <= coef_addr_reg - AW'(1);
        end
    end

    assign mul_a     = hist_qv_reg ? $signed(hist_q_reg) : '0;
    assign mul_b     = coef_qv_reg ? $signed(coef_q_reg) : '0;
    assign prod_next = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            prod_reg <= prod_next;
        end
    end

    // Clamp the product to 32 bits, then add with a clamped partial sum.
    always_comb begin
        prod_ovf   = (prod_reg[PW-1:KW-1] != '0) && (prod_reg[PW-1:KW-1] != '1);
        prod_clamp = prod_ovf ? {prod_reg[PW-1], {(KW-1){~prod_reg[PW-1]}}}
                              : prod_reg[KW-1:0];
        sum_wide   = {acc_reg[KW-1], acc_reg} + {prod_clamp[KW-1], prod_clamp};
        sum_ovf    = sum_wide[KW] != sum_wide[KW-1];
        acc_next   = sum_ovf ? {sum_wide[KW], {(KW-1){~sum_wide[KW]}}}
                             : sum_wide[KW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_next;
            sat_reg <= sat_reg || prod_ovf || sum_ovf;
        end
    end

    // Round half away from zero on the magnitude; only the low 16 bits of the
    // prediction reach the wrapped result.
    always_comb begin
        acc_neg   = acc_reg[KW-1];
        acc_mag   = acc_neg ? ((KW+1)'(0) - {acc_reg[KW-1], acc_reg}) : {1'b0, acc_reg};
        acc_rnd   = acc_mag + (KW+1)'(32768);
        quot      = acc_rnd[KW:16];
        pred_next = acc_neg ? SW'((KW-15)'(0) - quot) : quot[SW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == fprc_pkg::ST_ROUND) begin
            pred_reg <= pred_next;
        end
    end

    always_comb begin
        if (decode_reg) begin
            meas       = pred_reg + sample_reg;
            value_next = meas;
        end else begin
            meas       = sample_reg;
            value_next = sample_reg - pred_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_value_out_reg <= value_next;
            m_saturated_reg <= sat_reg;
        end
    end

endmodule
